// ----- design/top_k_score_tracker_core_assert.svh -----
// ----------------------------------------------------------------------------
// Top-k score tracker assertion macros
// Shared forms for the concurrent checks of the tracker core.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SCORE_TRACKER_CORE_ASSERT_SVH
`define TOP_K_SCORE_TRACKER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TKST_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tkst: same-cycle check failed");

// next-cycle implication, disabled in reset
`define TKST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tkst: next-cycle check failed");

`endif

// ----- design/tkst_pkg.sv -----
// ----------------------------------------------------------------------------
// Top-k score tracker package
// Shared widths, entry and control types for the tracker core and its cells.
// ----------------------------------------------------------------------------
package tkst_pkg;

  localparam int TOP_COUNT_DEF = 16;
  localparam int KEEP_W        = 5;
  localparam int OFFSET_W      = 32;
  localparam int SCORE_W       = 32;

  typedef struct packed {
    logic [OFFSET_W-1:0]       offset;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

  // where a cell stands relative to the limit and the current fill
  typedef struct packed {
    logic active;
    logic open;
  } cell_pos_t;

  typedef enum logic {
    PH_COLLECT,
    PH_DRAIN
  } phase_t;

endpackage

// ----- design/top_k_score_tracker_core.sv -----
// ----------------------------------------------------------------------------
// Top-k score tracker core
// Keeps the best keep_count (offset, score) items sorted by descending score.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one item per transfer, taken by a row
// of TOP_COUNT cells that all compare against the item at once; an item that
// ranks is written into its cell while every lower cell takes its upper
// neighbour, so a new item can follow in the next cycle.
// After an item with last_item set, the list is emitted on the output
// channel (out_valid / out_stall), best first, one entry per cycle while
// out_stall is low, with last_of_run on the final entry; the emit length
// equals the fill. in_stall is high for the whole emit phase. The output is
// cell 0 itself: a stall on the output holds the row and the current entry.
// Reset empties the list and sets keep_count to the built capacity, capped at
// the largest keep_count value; keep_count writes are taken at any time but
// are meant for idle periods, and a lowered keep_count trims the list at the
// next item. Zero is treated as one.
// ----------------------------------------------------------------------------
`include "top_k_score_tracker_core_assert.svh"

module top_k_score_tracker_core #(
  parameter int TOP_COUNT = tkst_pkg::TOP_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [tkst_pkg::KEEP_W-1:0]          cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tkst_pkg::OFFSET_W-1:0]        item_offset,
  input  logic signed [tkst_pkg::SCORE_W-1:0]  score,
  input  logic                                last_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tkst_pkg::OFFSET_W-1:0]        ranked_offset,
  output logic signed [tkst_pkg::SCORE_W-1:0]  ranked_score,
  output logic                                last_of_run
);

  localparam int CW        = $clog2(TOP_COUNT + 1);
  localparam int WW        = (CW > tkst_pkg::KEEP_W) ? CW : tkst_pkg::KEEP_W;
  localparam int KeepMax   = (1 << tkst_pkg::KEEP_W) - 1;
  localparam int KeepReset = (TOP_COUNT > KeepMax) ? KeepMax : TOP_COUNT;

  logic [tkst_pkg::KEEP_W-1:0] keep_count;
  logic [CW-1:0]               filled_count;
  logic [CW-1:0]               filled_count_next;
  logic [CW-1:0]               k_eff;
  logic [CW-1:0]               f_eff;
  logic [WW-1:0]               keep_wide;

  tkst_pkg::phase_t phase;
  tkst_pkg::phase_t phase_next;

  logic                        in_xfer;
  logic                        out_xfer;
  logic                        inserted;
  tkst_pkg::cell_ctrl_t        ctrl;
  tkst_pkg::entry_t            in_entry;
  tkst_pkg::entry_t            cell_entry [TOP_COUNT];
  logic [TOP_COUNT-1:0]        beats;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // clamp the limit to 1..TOP_COUNT
  assign keep_wide = WW'(keep_count);
  always_comb begin
    if (keep_wide == '0) begin
      k_eff = CW'(1);
    end else if (keep_wide > WW'(TOP_COUNT)) begin
      k_eff = CW'(TOP_COUNT);
    end else begin
      k_eff = CW'(keep_wide);
    end
  end

  // trim the fill when the limit was lowered
  assign f_eff = (filled_count > k_eff) ? k_eff : filled_count;

  assign in_entry.offset = item_offset;
  assign in_entry.score  = score;

  assign ctrl.insert = in_xfer;
  assign ctrl.drain  = out_xfer;

  // inactive cells never beat, so any beat means the item ranks
  assign inserted = |beats;

  generate
    for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
      tkst_pkg::cell_pos_t pos;
      logic                prev_beats;
      tkst_pkg::entry_t    prev_entry;
      tkst_pkg::entry_t    next_entry;

      assign pos.active = CW'(i) < k_eff;
      assign pos.open   = CW'(i) >= f_eff;

      if (i == 0) begin : g_head
        assign prev_beats = 1'b0;
        assign prev_entry = in_entry;
      end else begin : g_body
        assign prev_beats = beats[i-1];
        assign prev_entry = cell_entry[i-1];
      end

      if (i == TOP_COUNT - 1) begin : g_tail
        assign next_entry = cell_entry[i];
      end else begin : g_mid
        assign next_entry = cell_entry[i+1];
      end

      tkst_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .pos        (pos),
        .in_entry   (in_entry),
        .prev_beats (prev_beats),
        .prev_entry (prev_entry),
        .next_entry (next_entry),
        .beats      (beats[i]),
        .entry      (cell_entry[i])
      );
    end
  endgenerate

  // next state
  always_comb begin
    phase_next = phase;
    case (phase)
      tkst_pkg::PH_COLLECT: begin
        if (in_xfer && last_item) begin
          phase_next = tkst_pkg::PH_DRAIN;
        end
      end
      tkst_pkg::PH_DRAIN: begin
        if (out_xfer && (filled_count == CW'(1))) begin
          phase_next = tkst_pkg::PH_COLLECT;
        end
      end
      default: phase_next = tkst_pkg::PH_COLLECT;
    endcase
  end

  // outputs
  always_comb begin
    case (phase)
      tkst_pkg::PH_COLLECT: begin
        in_stall  = 1'b0;
        out_valid = 1'b0;
      end
      tkst_pkg::PH_DRAIN: begin
        in_stall  = 1'b1;
        out_valid = 1'b1;
      end
      default: begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
      end
    endcase
  end

  assign ranked_offset = cell_entry[0].offset;
  assign ranked_score  = cell_entry[0].score;
  assign last_of_run   = (filled_count == CW'(1));

  // the fill doubles as the emit count during drain
  always_comb begin
    filled_count_next = filled_count;
    if (in_xfer) begin
      if (inserted && (f_eff < k_eff)) begin
        filled_count_next = f_eff + CW'(1);
      end else begin
        filled_count_next = f_eff;
      end
    end else if (out_xfer) begin
      filled_count_next = filled_count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tkst_pkg::PH_COLLECT;
      filled_count <= '0;
      keep_count   <= tkst_pkg::KEEP_W'(KeepReset);
    end else begin
      phase        <= phase_next;
      filled_count <= filled_count_next;
      if (cfg_wr_en) begin
        keep_count <= cfg_wr_data;
      end
    end
  end

  `TKST_ASSERT_NEXT(a_last_starts_drain, clk, rst, in_xfer && last_item, out_valid)
  `TKST_ASSERT_NEXT(a_drain_ends, clk, rst, out_xfer && last_of_run, !out_valid)
  `TKST_ASSERT_NEXT(a_append_grows, clk, rst, in_xfer && (f_eff < k_eff), filled_count == ($past(f_eff) + CW'(1)))
  `TKST_ASSERT_NOW(a_drain_nonempty, clk, rst, phase == tkst_pkg::PH_DRAIN, filled_count != '0)

endmodule

// ----- design/tkst_cell.sv -----
// ----------------------------------------------------------------------------
// Top-k score tracker cell
// One rank of the sorted list: compares the broadcast item with its own entry,
// takes the item or its upper neighbour's entry on insert, and shifts up on
// drain.
// ----------------------------------------------------------------------------
module tkst_cell (
  input  logic                clk,
  input  tkst_pkg::cell_ctrl_t ctrl,
  input  tkst_pkg::cell_pos_t  pos,
  input  tkst_pkg::entry_t     in_entry,
  input  logic                prev_beats,
  input  tkst_pkg::entry_t     prev_entry,
  input  tkst_pkg::entry_t     next_entry,
  output logic                beats,
  output tkst_pkg::entry_t     entry
);

  tkst_pkg::entry_t entry_next;

  // strictly greater, so an equal score stays behind the earlier item
  assign beats = pos.active && (pos.open || (in_entry.score > entry.score));

  always_comb begin
    entry_next = entry;
    if (ctrl.drain) begin
      entry_next = next_entry;
    end else if (ctrl.insert) begin
      if (prev_beats) begin
        entry_next = prev_entry;
      end else if (beats) begin
        entry_next = in_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
